FILE: hw/rtl/bts_pkg.sv
// Package for the binary thinning subpass block.
// Field widths, register indexes, default limits and the result word type.
// No dependencies.
`default_nettype none

package bts_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int ROW_W      = 12;
	localparam int COL_W      = 10;
	localparam int CNT_W      = 22;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 13;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUBPASS      = 2'd2;

	// one pixel entering the decision stage
	typedef struct packed {
		logic             valid;
		logic             pix;
		logic             interior;
		logic             last;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} pix_ctl_t;

	// one result word
	typedef struct packed {
		logic [ROW_W-1:0] center_row;
		logic [COL_W-1:0] center_col;
		logic             new_pixel;
		logic             was_deleted;
		logic [CNT_W-1:0] deleted_total;
		logic             frame_last;
	} result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bts_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bts_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/bts_core.sv
// Decision stage: 3x3 window shift, Zhang-Suen test and saturating deletion count.
// Depends on bts_pkg.
`default_nettype none

module bts_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bts_pkg::pix_ctl_t ctl,
	input  wire logic [1:0]        line_bits,
	input  wire logic              subpass,
	input  wire logic              count_clr,
	output logic      [1:0]        line_wdata,
	output logic                   push,
	output bts_pkg::result_t       result
);

	logic [8:0]                window_q;
	logic [8:0]                win;
	logic [bts_pkg::CNT_W-1:0] count_q;
	logic [bts_pkg::CNT_W-1:0] count_nx;
	logic p2, p3, p4, p5, p6, p7, p8, p9, ctr;
	logic [7:0] ring;
	logic [7:0] rise;
	logic [3:0] a_cnt;
	logic [3:0] b_sum;
	logic m1, m2, mark, del;

	// column bits: up, mid, new pixel; oldest column in the low bits
	assign win = {ctl.pix, line_bits[1], line_bits[0], window_q[8:3]};
	assign line_wdata = {ctl.pix, line_bits[1]};

	assign p2  = win[3];
	assign p3  = win[6];
	assign p4  = win[7];
	assign p5  = win[8];
	assign p6  = win[5];
	assign p7  = win[2];
	assign p8  = win[1];
	assign p9  = win[0];
	assign ctr = win[4];

	assign ring  = {p9, p8, p7, p6, p5, p4, p3, p2};
	assign rise  = ~ring & {ring[0], ring[7:1]};
	assign a_cnt = 4'($countones(rise));
	assign b_sum = 4'($countones(ring));

	assign m1   = subpass ? (p2 & p4 & p8) : (p2 & p4 & p6);
	assign m2   = subpass ? (p2 & p6 & p8) : (p4 & p6 & p8);
	assign mark = (a_cnt == 4'd1) && (b_sum >= 4'd2) && (b_sum <= 4'd6) && !m1 && !m2;
	assign del  = mark & ctr;

	assign count_nx = (del && count_q != bts_pkg::CNT_MAX) ? count_q + 1'b1 : count_q;

	assign push = ctl.valid && ctl.interior;

	always_comb begin
		result.center_row    = ctl.row;
		result.center_col    = ctl.col;
		result.new_pixel     = ctr & ~mark;
		result.was_deleted   = del;
		result.deleted_total = count_nx;
		result.frame_last    = ctl.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			count_q  <= '0;
		end else begin
			if (ctl.valid) begin
				window_q <= win;
			end
			if (count_clr) begin
				count_q <= '0;
			end else if (push && ctl.last) begin
				count_q <= '0;
			end else if (push) begin
				count_q <= count_nx;
			end
		end
	end

	a_count_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(push && ctl.last) |=> (count_q == '0))
		else $error("deletion count not cleared after frame end");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !ctl.last && !count_clr) |=> (count_q == $past(count_nx)))
		else $error("deletion count update lost");

endmodule

`default_nettype wire

FILE: hw/rtl/bts_obuf.sv
// Two-word output queue between the decision stage and the result channel.
// Depends on bts_pkg.
`default_nettype none

module bts_obuf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire bts_pkg::result_t push_data,
	input  wire logic             pop,
	output logic      [1:0]       fill,
	output logic                  head_valid,
	output bts_pkg::result_t      head_data
);

	bts_pkg::result_t entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;

	assign fill       = fill_q;
	assign head_valid = fill_q != 2'd0;
	assign head_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && fill_q == 2'd2))
		else $error("output queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && fill_q == 2'd0))
		else $error("output queue underflow");

endmodule

`default_nettype wire

FILE: hw/rtl/binary_thinning_subpass.sv
// Top level of the binary thinning subpass: raster counters, line store, decision
// stage and output queue. Depends on bts_pkg, bts_ram, bts_core, bts_obuf.
// Throughput: one pixel per clock while in_stall is low, set by the line store's one read and one write port.
// Path: the pixel diagonally below-right of a center is registered with its line store read,
//   the decision stage forms the result word combinationally, and the word is registered
//   into the output queue, whose head drives the output.
// Reset clears counters, window, count and queue; line store contents are not cleared.
`default_nettype none

module binary_thinning_subpass #(
	parameter int MAX_WIDTH  = bts_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bts_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [bts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bts_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             pixel_bit,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [bts_pkg::ROW_W-1:0]        center_row,
	output logic      [bts_pkg::COL_W-1:0]        center_col,
	output logic                                  new_pixel,
	output logic                                  was_deleted,
	output logic      [bts_pkg::CNT_W-1:0]        deleted_total,
	output logic                                  frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [bts_pkg::IMG_W_W-1:0] image_width_q;
	logic [bts_pkg::IMG_H_W-1:0] image_height_q;
	logic                        subpass_q;
	logic                        dim_wr;

	logic [CW-1:0] w_last;
	logic [RW-1:0] h_last;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          accept;
	logic          col_end;
	logic          row_end;

	bts_pkg::pix_ctl_t ctl_s1;
	logic [CW-1:0]     addr_s1;

	logic [1:0]        line_rdata;
	logic [1:0]        line_wdata;
	logic              push;
	bts_pkg::result_t  push_data;
	logic [1:0]        fill;
	logic              pop;
	logic [2:0]        occ_next;
	bts_pkg::result_t  head;

	assign dim_wr = cfg_we && (cfg_index == bts_pkg::REG_IMAGE_WIDTH ||
		cfg_index == bts_pkg::REG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= bts_pkg::IMG_W_W'(1024);
			image_height_q <= bts_pkg::IMG_H_W'(1024);
			subpass_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				bts_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[bts_pkg::IMG_W_W-1:0];
				end
				bts_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data;
				end
				bts_pkg::REG_SUBPASS: begin
					subpass_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// clamp dimensions to 3..MAX
	always_comb begin
		if (image_width_q < bts_pkg::IMG_W_W'(3)) begin
			w_last = CW'(2);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			w_last = CW'(MAX_WIDTH - 1);
		end else begin
			w_last = CW'(image_width_q - 1'b1);
		end
		if (image_height_q < bts_pkg::IMG_H_W'(3)) begin
			h_last = RW'(2);
		end else if (32'(image_height_q) > 32'(MAX_HEIGHT)) begin
			h_last = RW'(MAX_HEIGHT - 1);
		end else begin
			h_last = RW'(image_height_q - 1'b1);
		end
	end

	assign pop      = out_valid && !out_stall;
	assign occ_next = {1'b0, fill} + {2'b0, ctl_s1.valid} - {2'b0, pop};
	assign in_stall = occ_next >= 3'd2;
	assign accept   = in_valid && !in_stall;
	assign col_end  = col_q == w_last;
	assign row_end  = row_q == h_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			ctl_s1  <= '0;
			addr_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			if (accept) begin
				ctl_s1.pix      <= pixel_bit;
				ctl_s1.interior <= (row_q >= RW'(2)) && (col_q >= CW'(2));
				ctl_s1.last     <= col_end && row_end;
				ctl_s1.row      <= bts_pkg::ROW_W'(row_q - 1'b1);
				ctl_s1.col      <= bts_pkg::COL_W'(col_q - 1'b1);
				addr_s1         <= col_q;
			end
			if (dim_wr) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	bts_ram #(
		.WIDTH(2),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (ctl_s1.valid),
		.waddr(addr_s1),
		.wdata(line_wdata),
		.re   (accept),
		.raddr(col_q),
		.rdata(line_rdata)
	);

	bts_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_s1),
		.line_bits (line_rdata),
		.subpass   (subpass_q),
		.count_clr (dim_wr),
		.line_wdata(line_wdata),
		.push      (push),
		.result    (push_data)
	);

	bts_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.fill      (fill),
		.head_valid(out_valid),
		.head_data (head)
	);

	assign center_row    = head.center_row;
	assign center_col    = head.center_col;
	assign new_pixel     = head.new_pixel;
	assign was_deleted   = head.was_deleted;
	assign deleted_total = head.deleted_total;
	assign frame_last    = head.frame_last;

	a_line_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && ctl_s1.valid && addr_s1 == col_q))
		else $error("line store read and write hit the same column");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (col_q <= w_last))
		else $error("column beyond row end");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Testbench for binary_thinning_subpass: streams binary frames, predicts every result word
// of the subpass and compares each one field by field. Depends on bts_pkg and the RTL only.
`timescale 1ns / 1ps

module testbench;

	import bts_pkg::*;

	localparam int DRAIN_CYCLES   = 8;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int QUIET_TAIL     = 200;
	localparam int NUM_DIRECTED   = 8;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef enum logic {ROW_CFG, ROW_FRAME} row_kind_t;

	// frame rows hold a 3x3 raster pattern, first pixel in data[8]
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  typed;
		result_t               res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic pixel_bit;
	logic out_valid;
	logic out_stall;
	logic [ROW_W-1:0] center_row;
	logic [COL_W-1:0] center_col;
	logic new_pixel;
	logic was_deleted;
	logic [CNT_W-1:0] deleted_total;
	logic frame_last;

	// thinning state mirrored from the block
	logic upper_line [MAX_WIDTH_DEF];
	logic middle_line [MAX_WIDTH_DEF];
	logic [8:0] win_bits;
	int col_pos;
	int row_pos;
	logic [CNT_W-1:0] del_count;
	logic [IMG_W_W-1:0] width_reg;
	logic [IMG_H_W-1:0] height_reg;
	logic subpass_reg;

	result_t thinned_q [$];
	int mismatch_count = 0;
	int sent_items = 0;
	int idle_cycles = 0;
	bit quiet = 0;
	bit long_hold_req = 0;
	logic typed_now = 1'b0;
	result_t typed_res = '0;
	dir_row_t directed_rows [NUM_DIRECTED];

	binary_thinning_subpass u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_bit(pixel_bit),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.center_row(center_row),
		.center_col(center_col),
		.new_pixel(new_pixel),
		.was_deleted(was_deleted),
		.deleted_total(deleted_total),
		.frame_last(frame_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp_dim(input int v, input int hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_IMAGE_WIDTH: begin
				width_reg = data[IMG_W_W-1:0];
				col_pos = 0;
				row_pos = 0;
				del_count = '0;
			end
			REG_IMAGE_HEIGHT: begin
				height_reg = data[IMG_H_W-1:0];
				col_pos = 0;
				row_pos = 0;
				del_count = '0;
			end
			REG_SUBPASS: begin
				subpass_reg = data[0];
			end
			default: begin
			end
		endcase
	endfunction

	// one pixel through the line stores and window; returns 1 when a word is due
	function automatic logic thin_step(input logic pix, output result_t res);
		int w, h, c, r, a, b, i;
		logic up, mid, m1, m2, mark, del;
		logic [7:0] ring;
		w = clamp_dim(width_reg, MAX_WIDTH_DEF);
		h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
		c = col_pos;
		r = row_pos;
		res = '0;
		thin_step = 1'b0;
		if (c >= w)
			c = w - 1;
		if (r >= h)
			r = h - 1;
		up = upper_line[c];
		mid = middle_line[c];
		upper_line[c] = mid;
		middle_line[c] = pix;
		win_bits = {pix, mid, up, win_bits[8:3]};
		if (r >= 2 && c >= 2) begin
			// ring[0] is north, clockwise to ring[7] north-west
			ring = {win_bits[0], win_bits[1], win_bits[2], win_bits[5],
				win_bits[8], win_bits[7], win_bits[6], win_bits[3]};
			a = 0;
			b = 0;
			for (i = 0; i < 8; i++) begin
				a += (!ring[i] && ring[(i + 1) % 8]) ? 1 : 0;
				b += ring[i] ? 1 : 0;
			end
			m1 = subpass_reg ? (ring[0] & ring[2] & ring[6]) : (ring[0] & ring[2] & ring[4]);
			m2 = subpass_reg ? (ring[0] & ring[4] & ring[6]) : (ring[2] & ring[4] & ring[6]);
			mark = (a == 1) && (b >= 2) && (b <= 6) && !m1 && !m2;
			del = mark & win_bits[4];
			if (del && del_count != CNT_MAX)
				del_count = del_count + 1'b1;
			res.center_row = ROW_W'(r - 1);
			res.center_col = COL_W'(c - 1);
			res.new_pixel = win_bits[4] & !mark;
			res.was_deleted = del;
			res.deleted_total = del_count;
			res.frame_last = (r == h - 1) && (c == w - 1);
			thin_step = 1'b1;
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) begin
				r = 0;
				del_count = '0;
			end
		end
		col_pos = c;
		row_pos = r;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		result_t got, predicted, want;
		logic produced;
		if (arst_n) begin
			if (cfg_we)
				apply_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall) begin
				produced = thin_step(pixel_bit, predicted);
				if (produced)
					thinned_q = {thinned_q, (typed_now ? typed_res : predicted)};
			end
			if (out_valid && !out_stall) begin
				got = '{center_row, center_col, new_pixel, was_deleted, deleted_total,
					frame_last};
				if (thinned_q.size() == 0) begin
					$display("%0t: expected no word, got row %0d col %0d", $time,
						center_row, center_col);
					mismatch_count++;
				end else begin
					want = thinned_q.pop_front();
					check_field("center_row", want.center_row, got.center_row);
					check_field("center_col", want.center_col, got.center_col);
					check_field("new_pixel", want.new_pixel, got.new_pixel);
					check_field("was_deleted", want.was_deleted, got.was_deleted);
					check_field("deleted_total", want.deleted_total, got.deleted_total);
					check_field("frame_last", want.frame_last, got.frame_last);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("CHECKS FAILED");
					$finish;
				end
			end
		end
	end

	// receiver: random stall bursts, plus one long hold on request
	initial begin
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (long_hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_req = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_pixel(input logic b, input logic typed, input result_t tres);
		if (!quiet && !long_hold_req && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_bit <= b;
		typed_now = typed;
		typed_res = tres;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		in_valid <= 1'b0;
		while (thinned_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_frame(input int n, input int density, input int sub_at);
		int k;
		for (k = 0; k < n; k++) begin
			if (k == sub_at)
				write_reg(REG_SUBPASS, CFG_DATA_W'($urandom_range(0, 1)));
			send_pixel($urandom_range(0, 99) < density, 1'b0, '0);
		end
	endtask

	initial begin
		int i, k, w_eff, h_eff, n, sub_at, reps, rand_start;
		logic [CFG_DATA_W-1:0] new_w, new_h;
		bit pressure_done;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_bit = 1'b0;
		for (i = 0; i < MAX_WIDTH_DEF; i++) begin
			upper_line[i] = 1'b0;
			middle_line[i] = 1'b0;
		end
		win_bits = '0;
		col_pos = 0;
		row_pos = 0;
		del_count = '0;
		width_reg = IMG_W_W'(1024);
		height_reg = IMG_H_W'(1024);
		subpass_reg = 1'b0;
		pressure_done = 0;

		directed_rows = '{
			'{ROW_CFG, REG_IMAGE_WIDTH, 13'd2, 1'b0, '0},
			'{ROW_CFG, REG_IMAGE_HEIGHT, 13'd0, 1'b0, '0},
			'{ROW_CFG, REG_NONE, 13'h1FFF, 1'b0, '0},
			// solid block: sum of neighbors 8, kept
			'{ROW_FRAME, REG_NONE, 13'b0000_111_111_111, 1'b1,
				'{12'd1, 10'd1, 1'b1, 1'b0, 22'd0, 1'b1}},
			// end point with south and south-east neighbors: removed
			'{ROW_FRAME, REG_NONE, 13'b0000_000_010_011, 1'b1,
				'{12'd1, 10'd1, 1'b0, 1'b1, 22'd1, 1'b1}},
			'{ROW_CFG, REG_SUBPASS, 13'd1, 1'b0, '0},
			// background center that still meets the removal test
			'{ROW_FRAME, REG_NONE, 13'b0000_000_000_011, 1'b1,
				'{12'd1, 10'd1, 1'b0, 1'b0, 22'd0, 1'b1}},
			'{ROW_FRAME, REG_NONE, 13'b0000_110_110_000, 1'b0, '0}
		};

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < NUM_DIRECTED; i++) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				for (k = 0; k < 9; k++)
					send_pixel(directed_rows[i].data[8 - k],
						directed_rows[i].typed && k == 8, directed_rows[i].res);
			end
		end

		// oversized width and height, clamped; only the start of each frame is streamed
		write_reg(REG_IMAGE_WIDTH, 13'd2047);
		write_reg(REG_IMAGE_HEIGHT, 13'd3);
		write_reg(REG_SUBPASS, 13'd0);
		run_frame(64, $urandom_range(20, 80), -1);
		write_reg(REG_IMAGE_WIDTH, 13'd3);
		write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
		write_reg(REG_SUBPASS, 13'd1);
		run_frame(3 * 60, $urandom_range(20, 80), -1);

		rand_start = sent_items;
		while (sent_items - rand_start < RANDOM_ITEMS) begin
			if (sent_items - rand_start >= RANDOM_ITEMS - QUIET_TAIL)
				quiet = 1;
			if ($urandom_range(0, 9) == 0)
				new_w = CFG_DATA_W'($urandom_range(0, 2));
			else if ($urandom_range(0, 4) == 0)
				new_w = CFG_DATA_W'($urandom_range(3, 40));
			else
				new_w = CFG_DATA_W'($urandom_range(3, 12));
			if ($urandom_range(0, 9) == 0)
				new_h = CFG_DATA_W'($urandom_range(0, 2));
			else
				new_h = CFG_DATA_W'($urandom_range(3, 10));
			if (!pressure_done && sent_items - rand_start > 600) begin
				new_w = 13'd12;
				new_h = 13'd12;
			end
			write_reg(REG_IMAGE_WIDTH, new_w);
			write_reg(REG_IMAGE_HEIGHT, new_h);
			write_reg(REG_SUBPASS, CFG_DATA_W'($urandom_range(0, 1)));
			w_eff = clamp_dim(new_w, MAX_WIDTH_DEF);
			h_eff = clamp_dim(new_h, MAX_HEIGHT_DEF);
			reps = $urandom_range(1, 2);
			for (k = 0; k < reps; k++) begin
				n = w_eff * h_eff;
				sub_at = -1;
				if (!pressure_done && sent_items - rand_start > 600) begin
					long_hold_req = 1;
					pressure_done = 1;
				end else begin
					if ($urandom_range(0, 5) == 0)
						n = $urandom_range(1, n - 1);
					if ($urandom_range(0, 5) == 0)
						sub_at = $urandom_range(1, n - 1);
				end
				run_frame(n, $urandom_range(10, 90), sub_at);
			end
		end

		in_valid <= 1'b0;
		while (thinned_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
